/* rtl/compaction_region_planner_core_assert.svh */
// Assertion macros used by the planner core RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef COMPACTION_REGION_PLANNER_CORE_ASSERT_SVH
`define COMPACTION_REGION_PLANNER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/crp_pkg.sv */
`default_nettype none

package crp_pkg;

  // Field widths.
  localparam int BYTES_W    = 64;
  localparam int KIND_W     = 3;
  localparam int PCT_W      = 7;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 11;
  localparam int PROD_W     = BYTES_W + PCT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Threshold above this percentage is rejected.
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // Region counters stop at their largest value.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  // Region kind codes.
  localparam logic [KIND_W-1:0] KIND_INVALID   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OLD       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PINNED    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LARGE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PERMANENT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OTHER     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVING    = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_ARG    = 2'd1,
    STATUS_BAD_REGION = 2'd2,
    STATUS_BUDGET     = 2'd3
  } crp_status_t;

  // One region descriptor as it enters the pipeline.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTES_W-1:0] capacity;
    logic [BYTES_W-1:0] used;
    logic [BYTES_W-1:0] live;
    logic               last;
  } crp_desc_t;

  // A screened region, handed from the screening pipeline to the accumulator.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               bad;
    logic               pinned;
    logic               cand;
    logic [BYTES_W-1:0] used;
    logic [BYTES_W-1:0] live;
    logic [BYTES_W-1:0] reclaim;
  } crp_screened_t;

  // The plan result.
  typedef struct packed {
    crp_status_t        status;
    logic [POS_W-1:0]   error_index;
    logic [CNT_W-1:0]   pinned_count;
    logic [BYTES_W-1:0] pinned_total;
    logic [CNT_W-1:0]   candidate_count;
    logic [BYTES_W-1:0] candidate_total;
    logic [BYTES_W-1:0] movable_total;
    logic [BYTES_W-1:0] planned_total;
    logic [BYTES_W-1:0] work_units;
    logic               eligible;
    logic               deferred;
    logic               moving_mode;
  } crp_result_t;

  // Add two byte counts, sticking at the largest value.
  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTES_W] ? BYTES_MAX : s[BYTES_W-1:0];
  endfunction

  // Step a region counter, sticking at the largest value.
  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/crp_if.sv */
`default_nettype none

// Region descriptor stream.
interface crp_region_if;
  import crp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  region_kind;
  logic [BYTES_W-1:0] capacity_bytes;
  logic [BYTES_W-1:0] used_bytes;
  logic [BYTES_W-1:0] live_bytes;
  logic               last_region;

  modport source (output valid, region_kind, capacity_bytes, used_bytes, live_bytes,
                  last_region, input ready);
  modport sink (input valid, region_kind, capacity_bytes, used_bytes, live_bytes,
                last_region, output ready);
endinterface

// Plan result stream.
interface crp_plan_if;
  import crp_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [POS_W-1:0]   error_index;
  logic [CNT_W-1:0]   pinned_count;
  logic [BYTES_W-1:0] pinned_total;
  logic [CNT_W-1:0]   candidate_count;
  logic [BYTES_W-1:0] candidate_total;
  logic [BYTES_W-1:0] movable_total;
  logic [BYTES_W-1:0] planned_total;
  logic [BYTES_W-1:0] work_units;
  logic               eligible;
  logic               deferred;
  logic               moving_mode;

  modport source (output valid, status, error_index, pinned_count, pinned_total,
                  candidate_count, candidate_total, movable_total, planned_total,
                  work_units, eligible, deferred, moving_mode, input ready);
  modport sink (input valid, status, error_index, pinned_count, pinned_total,
                candidate_count, candidate_total, movable_total, planned_total,
                work_units, eligible, deferred, moving_mode, output ready);
endinterface

`default_nettype wire

/* rtl/crp_screen.sv */
`default_nettype none

// Three-stage screening pipeline: captures a descriptor, validates and
// classifies it, then tests the fragmentation threshold. All stages move
// together when adv is high.
module crp_screen (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          adv,
  input  wire                          in_valid,
  input  wire crp_pkg::crp_desc_t      in_desc,
  input  wire [crp_pkg::PCT_W-1:0]     pct_i,
  output crp_pkg::crp_screened_t       screened_o
);
  import crp_pkg::*;

  // Stage one: the captured descriptor.
  logic      s1_valid_r;
  crp_desc_t s1_r;

  // Stage two: classification, reclaimable bytes and the threshold product.
  logic               s2_valid_r;
  logic               s2_last_r;
  logic               s2_bad_r;
  logic               s2_pinned_r;
  logic               s2_old_r;
  logic [BYTES_W-1:0] s2_used_r;
  logic [BYTES_W-1:0] s2_live_r;
  logic [BYTES_W-1:0] s2_reclaim_r;
  logic [PROD_W-1:0]  s2_prod_r;

  // Stage three: the screened region.
  crp_screened_t s3_r;

  logic               s2_bad_nxt;
  logic               s2_pinned_nxt;
  logic               s2_old_nxt;
  logic [PROD_W-1:0]  reclaim_x100;
  logic               meets;

  // Kind decode and range checks on the captured descriptor.
  always_comb begin
    s2_pinned_nxt = 1'b0;
    s2_old_nxt    = 1'b0;
    s2_bad_nxt    = (s1_r.used > s1_r.capacity) || (s1_r.live > s1_r.used);
    unique case (s1_r.kind)
      KIND_OLD: begin
        s2_old_nxt = 1'b1;
      end
      KIND_PINNED, KIND_LARGE, KIND_PERMANENT: begin
        s2_pinned_nxt = 1'b1;
      end
      KIND_OTHER: begin
      end
      default: begin
        s2_bad_nxt = 1'b1;
      end
    endcase
  end

  // Threshold test: with used and pct nonzero, reclaim * 100 >= used * pct, which
  // equals the rounded-down percentage comparison whenever the percentage is legal.
  assign reclaim_x100 = (PROD_W'(s2_reclaim_r) << 6) + (PROD_W'(s2_reclaim_r) << 5)
                      + (PROD_W'(s2_reclaim_r) << 2);

  always_comb begin
    if (s2_used_r == '0) begin
      meets = 1'b0;
    end else if (pct_i == '0) begin
      meets = (s2_reclaim_r != '0);
    end else begin
      meets = (reclaim_x100 >= s2_prod_r);
    end
  end

  // Stage registers; only the valid flags are reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s1_valid_r   <= in_valid;
      s2_valid_r   <= s1_valid_r;
      s3_r.valid   <= s2_valid_r;
      s1_r         <= in_desc;
      s2_last_r    <= s1_r.last;
      s2_bad_r     <= s2_bad_nxt;
      s2_pinned_r  <= s2_pinned_nxt;
      s2_old_r     <= s2_old_nxt;
      s2_used_r    <= s1_r.used;
      s2_live_r    <= s1_r.live;
      s2_reclaim_r <= s1_r.used - s1_r.live;
      s2_prod_r    <= PROD_W'(s1_r.used) * PROD_W'(pct_i);
      s3_r.last    <= s2_last_r;
      s3_r.bad     <= s2_bad_r;
      s3_r.pinned  <= s2_pinned_r;
      s3_r.cand    <= s2_old_r && meets;
      s3_r.used    <= s2_used_r;
      s3_r.live    <= s2_live_r;
      s3_r.reclaim <= s2_reclaim_r;
    end
  end

  assign screened_o = s3_r;

endmodule

`default_nettype wire

/* rtl/compaction_region_planner_core.sv */
// Compaction region planner. Region descriptors stream in one transaction per
// cycle while in_region.ready is high; the list ends with a descriptor whose
// last_region bit is set, and only that descriptor produces a result
// transaction, carrying the plan or an error status. A descriptor passes three
// screening registers (capture, classify with the used-times-percentage
// product, threshold compare) and is then folded into the running counts and
// sums, whose update is the loop that sets the rate of one descriptor per cycle.
// A finished plan waits in the output register and a second one in a spare
// register behind it, so the pipeline keeps moving while one plan is held; only
// when the spare is also full does in_region.ready drop, and it is then driven
// from that register alone.
// Configuration registers should only be written between lists, with the
// pipeline drained.
`default_nettype none

module compaction_region_planner_core (
  input  wire                              clk,
  input  wire                              rst_n,
  crp_region_if.sink                       in_region,
  crp_plan_if.source                       out_plan,
  input  wire                              cfg_we,
  input  wire [crp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [crp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import crp_pkg::*;

  `include "compaction_region_planner_core_assert.svh"

  // Configuration registers.
  logic [BYTES_W-1:0] budget_r;
  logic [PCT_W-1:0]   pct_r;
  logic               allow_moving_r;

  // Per-list state.
  logic [POS_W-1:0]   pos_r,          pos_nxt;
  logic               err_r,          err_nxt;
  logic [POS_W-1:0]   err_pos_r,      err_pos_nxt;
  logic [CNT_W-1:0]   pinned_cnt_r,   pinned_cnt_nxt;
  logic [BYTES_W-1:0] pinned_sum_r,   pinned_sum_nxt;
  logic [CNT_W-1:0]   cand_cnt_r,     cand_cnt_nxt;
  logic [BYTES_W-1:0] cand_sum_r,     cand_sum_nxt;
  logic [BYTES_W-1:0] movable_sum_r,  movable_sum_nxt;
  logic [BYTES_W-1:0] planned_sum_r,  planned_sum_nxt;
  logic [CNT_W-1:0]   planned_cnt_r,  planned_cnt_nxt;
  logic               budget_hit_r,   budget_hit_nxt;

  // Result register and the spare behind it.
  logic               out_valid_r;
  crp_result_t        res_r, res_nxt;
  logic               spare_valid_r;
  crp_result_t        spare_r;

  logic               adv;
  logic               acc_fire;
  logic               plan_done;
  logic               out_free;
  crp_desc_t          in_desc;
  crp_screened_t      sc;
  logic               over_budget;
  logic [BYTES_W:0]   plan_add;
  logic               budget_miss;

  // The pipeline moves unless the spare plan register is occupied.
  assign adv             = !spare_valid_r;
  assign in_region.ready = adv;
  assign acc_fire        = adv && sc.valid;
  assign plan_done       = acc_fire && sc.last;
  assign out_free        = !out_valid_r || out_plan.ready;

  assign in_desc.kind     = in_region.region_kind;
  assign in_desc.capacity = in_region.capacity_bytes;
  assign in_desc.used     = in_region.used_bytes;
  assign in_desc.live     = in_region.live_bytes;
  assign in_desc.last     = in_region.last_region;

  crp_screen u_screen (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_region.valid),
    .in_desc    (in_desc),
    .pct_i      (pct_r),
    .screened_o (sc)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r       <= '0;
      pct_r          <= '0;
      allow_moving_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUDGET:    budget_r       <= cfg_data[BYTES_W-1:0];
        CFG_THRESHOLD: pct_r          <= cfg_data[PCT_W-1:0];
        CFG_MOVING:    allow_moving_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Budget admission. When the budget is nonzero and the planned sum already
  // exceeds it there is no room, so only a region with no live bytes gets in.
  assign over_budget = (planned_sum_r > budget_r);
  assign plan_add    = {1'b0, planned_sum_r} + {1'b0, sc.live};
  assign budget_miss = (budget_r != '0) &&
                       (over_budget ? (sc.live != '0) : (plan_add > {1'b0, budget_r}));

  // Fold one screened region into the running state.
  always_comb begin
    pos_nxt         = pos_r + POS_W'(1);
    err_nxt         = err_r;
    err_pos_nxt     = err_pos_r;
    pinned_cnt_nxt  = pinned_cnt_r;
    pinned_sum_nxt  = pinned_sum_r;
    cand_cnt_nxt    = cand_cnt_r;
    cand_sum_nxt    = cand_sum_r;
    movable_sum_nxt = movable_sum_r;
    planned_sum_nxt = planned_sum_r;
    planned_cnt_nxt = planned_cnt_r;
    budget_hit_nxt  = budget_hit_r;
    if (!err_r) begin
      if (sc.bad) begin
        err_nxt     = 1'b1;
        err_pos_nxt = pos_r;
      end else if (sc.pinned) begin
        pinned_cnt_nxt = cnt_inc(pinned_cnt_r);
        pinned_sum_nxt = sat_add(pinned_sum_r, sc.used);
      end else if (sc.cand) begin
        cand_cnt_nxt    = cnt_inc(cand_cnt_r);
        cand_sum_nxt    = sat_add(cand_sum_r, sc.reclaim);
        movable_sum_nxt = sat_add(movable_sum_r, sc.live);
        if (allow_moving_r) begin
          if (budget_miss) begin
            budget_hit_nxt = 1'b1;
          end else begin
            planned_sum_nxt = plan_add[BYTES_W] ? BYTES_MAX : plan_add[BYTES_W-1:0];
            planned_cnt_nxt = cnt_inc(planned_cnt_r);
          end
        end
      end
    end
  end

  // Build the result from the state after this region. With a nonzero budget the
  // planned sum only ends above the budget if it was already above it.
  always_comb begin
    res_nxt = '0;
    if (pct_r > PCT_MAX) begin
      res_nxt.status = STATUS_BAD_ARG;
    end else if (err_nxt) begin
      res_nxt.status      = STATUS_BAD_REGION;
      res_nxt.error_index = err_pos_nxt;
    end else if (allow_moving_r && (budget_r != '0) && over_budget) begin
      res_nxt.status = STATUS_BUDGET;
    end else begin
      res_nxt.status          = STATUS_OK;
      res_nxt.pinned_count    = pinned_cnt_nxt;
      res_nxt.pinned_total    = pinned_sum_nxt;
      res_nxt.candidate_count = cand_cnt_nxt;
      res_nxt.candidate_total = cand_sum_nxt;
      res_nxt.movable_total   = movable_sum_nxt;
      res_nxt.moving_mode     = allow_moving_r;
      if (allow_moving_r) begin
        res_nxt.planned_total = planned_sum_nxt;
        res_nxt.eligible      = (planned_cnt_nxt != '0);
        res_nxt.deferred      = budget_hit_nxt || (planned_cnt_nxt < cand_cnt_nxt);
      end else begin
        res_nxt.deferred      = (cand_cnt_nxt != '0);
      end
      res_nxt.work_units = res_nxt.eligible ? planned_sum_nxt : movable_sum_nxt;
    end
  end

  // Running state; the last region of a list clears it.
  always_ff @(posedge clk) begin
    if (!rst_n || plan_done) begin
      pos_r         <= '0;
      err_r         <= 1'b0;
      err_pos_r     <= '0;
      pinned_cnt_r  <= '0;
      pinned_sum_r  <= '0;
      cand_cnt_r    <= '0;
      cand_sum_r    <= '0;
      movable_sum_r <= '0;
      planned_sum_r <= '0;
      planned_cnt_r <= '0;
      budget_hit_r  <= 1'b0;
    end else if (acc_fire) begin
      pos_r         <= pos_nxt;
      err_r         <= err_nxt;
      err_pos_r     <= err_pos_nxt;
      pinned_cnt_r  <= pinned_cnt_nxt;
      pinned_sum_r  <= pinned_sum_nxt;
      cand_cnt_r    <= cand_cnt_nxt;
      cand_sum_r    <= cand_sum_nxt;
      movable_sum_r <= movable_sum_nxt;
      planned_sum_r <= planned_sum_nxt;
      planned_cnt_r <= planned_cnt_nxt;
      budget_hit_r  <= budget_hit_nxt;
    end
  end

  // Result transaction flags. A plan finished while the output register is
  // still held goes to the spare, which moves forward once the output is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= spare_valid_r || plan_done;
      end
      if (spare_valid_r) begin
        if (out_plan.ready) begin
          spare_valid_r <= 1'b0;
        end
      end else if (plan_done && !out_free) begin
        spare_valid_r <= 1'b1;
      end
    end
  end

  // Result transaction payloads.
  always_ff @(posedge clk) begin
    if (out_free && spare_valid_r) begin
      res_r <= spare_r;
    end else if (out_free && plan_done) begin
      res_r <= res_nxt;
    end
    if (plan_done && !out_free) begin
      spare_r <= res_nxt;
    end
  end

  assign out_plan.valid           = out_valid_r;
  assign out_plan.status          = res_r.status;
  assign out_plan.error_index     = res_r.error_index;
  assign out_plan.pinned_count    = res_r.pinned_count;
  assign out_plan.pinned_total    = res_r.pinned_total;
  assign out_plan.candidate_count = res_r.candidate_count;
  assign out_plan.candidate_total = res_r.candidate_total;
  assign out_plan.movable_total   = res_r.movable_total;
  assign out_plan.planned_total   = res_r.planned_total;
  assign out_plan.work_units      = res_r.work_units;
  assign out_plan.eligible        = res_r.eligible;
  assign out_plan.deferred        = res_r.deferred;
  assign out_plan.moving_mode     = res_r.moving_mode;

  // The last region of a list leaves the position counter at zero.
  `CRP_ASSERT_NEXT(a_list_clear, acc_fire && sc.last, pos_r == '0, "list state not cleared")

  // An error result carries no plan.
  `CRP_ASSERT_SAME(a_error_empty, out_valid_r && (res_r.status != STATUS_OK),
    (res_r.pinned_count == '0) && (res_r.work_units == '0) && !res_r.moving_mode,
    "error result carries plan fields")

  // A planned move only happens in moving mode and sets the work units.
  `CRP_ASSERT_SAME(a_eligible_mode, out_valid_r && res_r.eligible,
    res_r.moving_mode && (res_r.work_units == res_r.planned_total),
    "eligible plan inconsistent")

  // Every planned region is also a candidate.
  `CRP_ASSERT_SAME(a_planned_le_cand, 1'b1, planned_cnt_r <= cand_cnt_r,
    "more planned than candidate regions")

  // The spare only fills behind a plan that is already on offer.
  `CRP_ASSERT_SAME(a_spare_behind, spare_valid_r, out_valid_r,
    "spare plan held with the output empty")

endmodule

`default_nettype wire
